[hw/rtl/triangle_split_plane_box_clip_unit_defines.svh]
// Assertion macros shared by the checker of the triangle split-plane box clip unit.
// Depends on nothing; pulled in by the checker file.
`ifndef TRIANGLE_SPLIT_PLANE_BOX_CLIP_UNIT_DEFINES_SVH
`define TRIANGLE_SPLIT_PLANE_BOX_CLIP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TSPBC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define TSPBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/tspbc_pkg.sv]
// Shared constants, axis codes and per-edge flag type of the split-plane box clip unit.
// Depends on nothing.
package tspbc_pkg;

  localparam int COORD_BITS_DEF = 32;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  localparam logic [1:0] AXIS_WRAP [5] = '{AXIS_X, AXIS_Y, AXIS_Z, AXIS_X, AXIS_Y};

  typedef struct packed {
    logic straddle;  // endpoints strictly on opposite sides
    logic s_le;      // first vertex at or left of the plane
    logic s_ge;      // first vertex at or right of the plane
  } edge_flags_t;

  function automatic logic [1:0] axis_wrap(input logic [2:0] n);
    return (n > 3'd4) ? AXIS_X : AXIS_WRAP[n];
  endfunction

endpackage

[hw/rtl/tspbc_front.sv]
// Front end: classify edges against the plane, form differences, then multiply.
// Depends on tspbc_pkg.
module tspbc_front import tspbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int D = COORD_BITS + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_vld,
  input  logic [2:0][2:0][COORD_BITS-1:0]     vtx,
  input  logic [COORD_BITS-1:0]               pos,
  input  logic [1:0]                          axis,
  output logic                                out_vld,
  output logic [5:0][2*D-1:0]                 prod,
  output logic [2:0][D-1:0]                   dvs,
  output logic [2:0][2:0][COORD_BITS-1:0]     vtx_o,
  output logic [COORD_BITS-1:0]               pos_o,
  output logic [1:0]                          k_o,
  output edge_flags_t [2:0]                   flags_o,
  output logic [5:0]                          neg_o,
  output logic                                beyond_o
);

  function automatic logic [D-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                           input logic [COORD_BITS-1:0] b);
    logic signed [D-1:0] df;
    df = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    return df[D-1] ? D'(-df) : D'(df);
  endfunction

  // Distances never exceed the coordinate span, so the product needs only
  // COORD_BITS-wide operands.
  function automatic logic [2*COORD_BITS-1:0] umul(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b);
    return a * b;
  endfunction

  // stage 1 combinational
  logic [1:0]                  k;
  logic [2:0][COORD_BITS-1:0]  ak;
  logic [COORD_BITS-1:0]       mn, mx;
  logic [2:0][D-1:0]           t_c, d_c;
  logic [5:0][D-1:0]           du_c;
  logic [5:0]                  neg_c;
  edge_flags_t [2:0]           fl_c;
  logic                        beyond_c;

  always_comb begin
    logic [1:0] b, u;
    k = (axis > AXIS_Z) ? AXIS_X : axis;
    for (int i = 0; i < 3; i++) ak[i] = vtx[i][k];
    mn = ak[0];
    mx = ak[0];
    for (int i = 1; i < 3; i++) begin
      if ($signed(ak[i]) < $signed(mn)) mn = ak[i];
      if ($signed(ak[i]) > $signed(mx)) mx = ak[i];
    end
    beyond_c = ($signed(mn) > $signed(pos)) || ($signed(mx) < $signed(pos));
    for (int i = 0; i < 3; i++) begin
      b = axis_wrap(3'(i + 1));
      fl_c[i].straddle = ($signed(ak[i]) < $signed(pos) && $signed(pos) < $signed(ak[b])) ||
                         ($signed(ak[b]) < $signed(pos) && $signed(pos) < $signed(ak[i]));
      fl_c[i].s_le = $signed(ak[i]) <= $signed(pos);
      fl_c[i].s_ge = $signed(ak[i]) >= $signed(pos);
      t_c[i] = absdiff(pos, ak[i]);
      d_c[i] = absdiff(ak[b], ak[i]);
      for (int j = 0; j < 2; j++) begin
        u = axis_wrap(3'(k) + 3'(j + 1));
        du_c[2*i+j]  = absdiff(vtx[b][u], vtx[i][u]);
        neg_c[2*i+j] = $signed(vtx[b][u]) < $signed(vtx[i][u]);
      end
    end
  end

  logic                              vld1;
  logic [2:0][D-1:0]                 t1;
  logic [5:0][D-1:0]                 du1;
  logic [2:0][D-1:0]                 d1;
  logic [2:0][2:0][COORD_BITS-1:0]   vtx1;
  logic [COORD_BITS-1:0]             pos1;
  logic [1:0]                        k1;
  edge_flags_t [2:0]                 fl1;
  logic [5:0]                        neg1;
  logic                              beyond1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    t1 <= t_c;
    du1 <= du_c;
    d1 <= d_c;
    vtx1 <= vtx;
    pos1 <= pos;
    k1 <= k;
    fl1 <= fl_c;
    neg1 <= neg_c;
    beyond1 <= beyond_c;
    // stage 2: one product per edge and off-axis
    for (int l = 0; l < 6; l++)
      prod[l] <= (2*D)'(umul(t1[l/2][COORD_BITS-1:0], du1[l][COORD_BITS-1:0]));
    dvs <= d1;
    vtx_o <= vtx1;
    pos_o <= pos1;
    k_o <= k1;
    flags_o <= fl1;
    neg_o <= neg1;
    beyond_o <= beyond1;
  end

endmodule

[hw/rtl/tspbc_div.sv]
// Pipelined restoring divider bank, one quotient bit per stage, with a side word
// carried alongside. Depends on tspbc_pkg.
module tspbc_div import tspbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int LANES = 6,
  parameter int SBW = 1,
  localparam int D = COORD_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  logic [LANES-1:0][2*D-1:0]   dividend,
  input  logic [LANES-1:0][D-1:0]     divisor,
  input  logic [SBW-1:0]              sb_in,
  output logic                        out_vld,
  output logic [LANES-1:0][D-1:0]     quot,
  output logic [SBW-1:0]              sb_out
);

  logic [LANES-1:0][D-1:0] rem [D+1];
  logic [LANES-1:0][D-1:0] lo  [D+1];
  logic [LANES-1:0][D-1:0] dv  [D+1];
  logic [LANES-1:0][D-1:0] q   [D+1];
  logic [SBW-1:0]          sb  [D+1];
  logic                    vld [D+1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] = dividend[l][2*D-1:D];
      lo[0][l]  = dividend[l][D-1:0];
      dv[0][l]  = divisor[l];
      q[0][l]   = '0;
    end
    sb[0]  = sb_in;
    vld[0] = in_vld;
  end

  for (genvar g = 0; g < D; g++) begin : g_stage
    logic [LANES-1:0][D:0] trial;
    logic [LANES-1:0]      ge;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem[g][l], lo[g][l][D-1]};
        ge[l]    = trial[l] >= {1'b0, dv[g][l]};
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < LANES; l++) begin
        rem[g+1][l] <= ge[l] ? D'(trial[l] - {1'b0, dv[g][l]}) : trial[l][D-1:0];
        lo[g+1][l]  <= {lo[g][l][D-2:0], 1'b0};
        q[g+1][l]   <= {q[g][l][D-2:0], ge[l]};
        dv[g+1][l]  <= dv[g][l];
      end
      sb[g+1] <= sb[g];
    end

    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else vld[g+1] <= vld[g];
    end
  end

  assign quot    = q[D];
  assign sb_out  = sb[D];
  assign out_vld = vld[D];

endmodule

[hw/rtl/tspbc_box.sv]
// Box builder: crossing points, per-edge point pairs, then two merge stages
// into the left and right boxes. Depends on tspbc_pkg.
module tspbc_box import tspbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int D = COORD_BITS + 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_vld,
  input  logic [2:0][2:0][COORD_BITS-1:0]      vtx,
  input  logic [COORD_BITS-1:0]                pos,
  input  logic [1:0]                           k,
  input  edge_flags_t [2:0]                    flags,
  input  logic [5:0]                           neg,
  input  logic                                 beyond,
  input  logic [5:0][D-1:0]                    quot,
  output logic                                 out_vld,
  output logic [1:0][2:0][COORD_BITS-1:0]      box_lo,
  output logic [1:0][2:0][COORD_BITS-1:0]      box_hi,
  output logic [1:0]                           box_en
);

  function automatic logic [COORD_BITS-1:0] smin(input logic [COORD_BITS-1:0] a,
      input logic ea, input logic [COORD_BITS-1:0] b, input logic eb);
    if (!ea) return b;
    if (!eb) return a;
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic logic [COORD_BITS-1:0] smax(input logic [COORD_BITS-1:0] a,
      input logic ea, input logic [COORD_BITS-1:0] b, input logic eb);
    if (!ea) return b;
    if (!eb) return a;
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  // stage A: crossing point and the two points each side takes from each edge
  logic [1:0][2:0][2:0][COORD_BITS-1:0] lo_c, hi_c;  // [side][edge][axis]
  logic [1:0][2:0]                      en_c;

  always_comb begin
    logic [1:0]                  b;
    logic                        slot;
    logic [D-1:0]                base, val;
    logic [2:0][COORD_BITS-1:0]  x, pa, pb, p1, p2, r1, r2;
    for (int i = 0; i < 3; i++) begin
      b = axis_wrap(3'(i + 1));
      for (int ax = 0; ax < 3; ax++) begin
        slot = (2'(ax) != axis_wrap(3'(k) + 3'd1));
        base = {vtx[i][ax][COORD_BITS-1], vtx[i][ax]};
        val  = neg[2*i+int'(slot)] ? base - quot[2*i+int'(slot)]
                                   : base + quot[2*i+int'(slot)];
        x[ax] = (2'(ax) == k) ? pos : val[COORD_BITS-1:0];
      end
      pa = vtx[i];
      pb = vtx[b];
      p1 = flags[i].straddle ? x : pa;
      p2 = flags[i].straddle ? (flags[i].s_le ? pa : pb) : pb;
      r1 = flags[i].straddle ? x : pa;
      r2 = flags[i].straddle ? (flags[i].s_le ? pb : pa) : pb;
      for (int ax = 0; ax < 3; ax++) begin
        lo_c[SIDE_LEFT][i][ax]  = smin(p1[ax], 1'b1, p2[ax], 1'b1);
        hi_c[SIDE_LEFT][i][ax]  = smax(p1[ax], 1'b1, p2[ax], 1'b1);
        lo_c[SIDE_RIGHT][i][ax] = smin(r1[ax], 1'b1, r2[ax], 1'b1);
        hi_c[SIDE_RIGHT][i][ax] = smax(r1[ax], 1'b1, r2[ax], 1'b1);
      end
      en_c[SIDE_LEFT][i]  = !beyond && (flags[i].straddle || flags[i].s_le);
      en_c[SIDE_RIGHT][i] = !beyond && (flags[i].straddle || flags[i].s_ge);
    end
  end

  logic [1:0][2:0][2:0][COORD_BITS-1:0] lo_a, hi_a;
  logic [1:0][2:0]                      en_a;
  logic [1:0][2:0][COORD_BITS-1:0]      lo_b, hi_b, lo_e2, hi_e2;
  logic [1:0]                           en_b, en_e2;
  logic                                 vld_a, vld_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a   <= 1'b0;
      vld_b   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld_a   <= in_vld;
      vld_b   <= vld_a;
      out_vld <= vld_b;
    end
  end

  always_ff @(posedge clk) begin
    lo_a <= lo_c;
    hi_a <= hi_c;
    en_a <= en_c;
    for (int s = 0; s < 2; s++) begin
      // stage B: fold edges 0 and 1 together, carry edge 2 alongside
      for (int ax = 0; ax < 3; ax++) begin
        lo_b[s][ax]  <= smin(lo_a[s][0][ax], en_a[s][0], lo_a[s][1][ax], en_a[s][1]);
        hi_b[s][ax]  <= smax(hi_a[s][0][ax], en_a[s][0], hi_a[s][1][ax], en_a[s][1]);
        lo_e2[s][ax] <= lo_a[s][2][ax];
        hi_e2[s][ax] <= hi_a[s][2][ax];
      end
      en_b[s]  <= en_a[s][0] | en_a[s][1];
      en_e2[s] <= en_a[s][2];
      // stage C: fold edge 2 into the merged pair
      for (int ax = 0; ax < 3; ax++) begin
        box_lo[s][ax] <= smin(lo_b[s][ax], en_b[s], lo_e2[s][ax], en_e2[s]);
        box_hi[s][ax] <= smax(hi_b[s][ax], en_b[s], hi_e2[s][ax], en_e2[s]);
      end
      box_en[s] <= en_b[s] | en_e2[s];
    end
  end

endmodule

[hw/rtl/triangle_split_plane_box_clip_unit.sv]
// Top level of the triangle split-plane box clip unit.
// Depends on tspbc_pkg, tspbc_front, tspbc_div and tspbc_box.
//
// Usage:
//   Present a triangle (three signed vertices), plane_pos and plane_axis and
//   raise start; the word is taken at a clock edge where start is high and
//   busy is low. busy is high in the cycle after each accepted word, so
//   no new triangle can enter directly behind an accepted one.
//   Each triangle yields two result words, each shown for exactly one cycle
//   with strobe high: the left box (side 0, last 0) and, in the very next
//   cycle, the right box (side 1, last 1). A side that received no points,
//   including both sides of a triangle wholly beyond the plane, shows
//   present 0 and all box fields zero.
//   The left word passes an input register, two front stages (classify,
//   multiply), COORD_BITS + 1 divider stages (one quotient bit each), three
//   box stages and the output register. The two result words per triangle
//   share a single result port, which is why busy holds off the next word.
//   The receiver cannot stall; nothing in the pipeline ever holds.
//   Reset clears all valid bits and the output strobe; in-flight words drop.
module triangle_split_plane_box_clip_unit import tspbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_BITS-1:0]  a_x,
  input  logic [COORD_BITS-1:0]  a_y,
  input  logic [COORD_BITS-1:0]  a_z,
  input  logic [COORD_BITS-1:0]  b_x,
  input  logic [COORD_BITS-1:0]  b_y,
  input  logic [COORD_BITS-1:0]  b_z,
  input  logic [COORD_BITS-1:0]  c_x,
  input  logic [COORD_BITS-1:0]  c_y,
  input  logic [COORD_BITS-1:0]  c_z,
  input  logic [COORD_BITS-1:0]  plane_pos,
  input  logic [1:0]             plane_axis,
  output logic                   strobe,
  output logic                   side,
  output logic                   present,
  output logic [COORD_BITS-1:0]  min_x,
  output logic [COORD_BITS-1:0]  min_y,
  output logic [COORD_BITS-1:0]  min_z,
  output logic [COORD_BITS-1:0]  max_x,
  output logic [COORD_BITS-1:0]  max_y,
  output logic [COORD_BITS-1:0]  max_z,
  output logic                   last
);

  localparam int D   = COORD_BITS + 1;
  // side word carried beside the divider: beyond, axis, edge flags, signs, plane, vertices
  localparam int SBW = 1 + 2 + 3 * $bits(edge_flags_t) + 6 + COORD_BITS + 9 * COORD_BITS;

  logic accept;
  assign accept = start && !busy;

  // Hold off the word after each accept: two results per triangle share one port.
  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b0;
    else busy <= accept;
  end

  // Input register.
  logic                             vld0;
  logic [2:0][2:0][COORD_BITS-1:0]  vtx0;
  logic [COORD_BITS-1:0]            pos0;
  logic [1:0]                       axis0;

  always_ff @(posedge clk) begin
    if (rst) vld0 <= 1'b0;
    else vld0 <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vtx0  <= {c_z, c_y, c_x, b_z, b_y, b_x, a_z, a_y, a_x};
      pos0  <= plane_pos;
      axis0 <= plane_axis;
    end
  end

  // Front end: classify and multiply.
  logic                             f_vld;
  logic [5:0][2*D-1:0]              f_prod;
  logic [2:0][D-1:0]                f_dvs;
  logic [2:0][2:0][COORD_BITS-1:0]  f_vtx;
  logic [COORD_BITS-1:0]            f_pos;
  logic [1:0]                       f_k;
  edge_flags_t [2:0]                f_flags;
  logic [5:0]                       f_neg;
  logic                             f_beyond;

  tspbc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (vld0),
    .vtx      (vtx0),
    .pos      (pos0),
    .axis     (axis0),
    .out_vld  (f_vld),
    .prod     (f_prod),
    .dvs      (f_dvs),
    .vtx_o    (f_vtx),
    .pos_o    (f_pos),
    .k_o      (f_k),
    .flags_o  (f_flags),
    .neg_o    (f_neg),
    .beyond_o (f_beyond)
  );

  // Each edge divisor feeds both off-axis lanes of that edge.
  logic [5:0][D-1:0] lane_dvs;
  always_comb begin
    for (int l = 0; l < 6; l++) lane_dvs[l] = f_dvs[l/2];
  end

  logic [SBW-1:0]                   sb_in, sb_out;
  logic                             d_vld;
  logic [5:0][D-1:0]                d_quot;
  logic [2:0][2:0][COORD_BITS-1:0]  d_vtx;
  logic [COORD_BITS-1:0]            d_pos;
  logic [1:0]                       d_k;
  edge_flags_t [2:0]                d_flags;
  logic [5:0]                       d_neg;
  logic                             d_beyond;

  assign sb_in = {f_beyond, f_k, f_flags, f_neg, f_pos, f_vtx};
  assign {d_beyond, d_k, d_flags, d_neg, d_pos, d_vtx} = sb_out;

  tspbc_div #(.COORD_BITS(COORD_BITS), .LANES(6), .SBW(SBW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (f_vld),
    .dividend (f_prod),
    .divisor  (lane_dvs),
    .sb_in    (sb_in),
    .out_vld  (d_vld),
    .quot     (d_quot),
    .sb_out   (sb_out)
  );

  logic                                b_vld;
  logic [1:0][2:0][COORD_BITS-1:0]     b_lo, b_hi;
  logic [1:0]                          b_en;

  tspbc_box #(.COORD_BITS(COORD_BITS)) u_box (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (d_vld),
    .vtx     (d_vtx),
    .pos     (d_pos),
    .k       (d_k),
    .flags   (d_flags),
    .neg     (d_neg),
    .beyond  (d_beyond),
    .quot    (d_quot),
    .out_vld (b_vld),
    .box_lo  (b_lo),
    .box_hi  (b_hi),
    .box_en  (b_en)
  );

  // Output register: left word first, then the right word from the rh_* hold registers in the next cycle.
  logic                             pend;
  logic [2:0][COORD_BITS-1:0]       rh_lo, rh_hi;
  logic                             rh_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      pend   <= 1'b0;
    end else begin
      strobe <= b_vld | pend;
      pend   <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld) begin
      side    <= SIDE_LEFT;
      last    <= 1'b0;
      present <= b_en[SIDE_LEFT];
      min_x   <= b_en[SIDE_LEFT] ? b_lo[SIDE_LEFT][0] : '0;
      min_y   <= b_en[SIDE_LEFT] ? b_lo[SIDE_LEFT][1] : '0;
      min_z   <= b_en[SIDE_LEFT] ? b_lo[SIDE_LEFT][2] : '0;
      max_x   <= b_en[SIDE_LEFT] ? b_hi[SIDE_LEFT][0] : '0;
      max_y   <= b_en[SIDE_LEFT] ? b_hi[SIDE_LEFT][1] : '0;
      max_z   <= b_en[SIDE_LEFT] ? b_hi[SIDE_LEFT][2] : '0;
      rh_lo   <= b_lo[SIDE_RIGHT];
      rh_hi   <= b_hi[SIDE_RIGHT];
      rh_en   <= b_en[SIDE_RIGHT];
    end else if (pend) begin
      side    <= SIDE_RIGHT;
      last    <= 1'b1;
      present <= rh_en;
      min_x   <= rh_en ? rh_lo[0] : '0;
      min_y   <= rh_en ? rh_lo[1] : '0;
      min_z   <= rh_en ? rh_lo[2] : '0;
      max_x   <= rh_en ? rh_hi[0] : '0;
      max_y   <= rh_en ? rh_hi[1] : '0;
      max_z   <= rh_en ? rh_hi[2] : '0;
    end
  end

endmodule

[hw/rtl/tspbc_checker.sv]
// Port-level checker for the split-plane box clip unit, bound to the top level.
// Depends on tspbc_pkg and triangle_split_plane_box_clip_unit_defines.svh.
`include "triangle_split_plane_box_clip_unit_defines.svh"

module tspbc_checker import tspbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   strobe,
  input logic                   side,
  input logic                   present,
  input logic [COORD_BITS-1:0]  min_x,
  input logic [COORD_BITS-1:0]  max_z,
  input logic                   last
);

  // An accepted word blocks the next cycle.
  `TSPBC_ASSERT_NEXT(a_busy_after_accept, clk, rst, start && !busy, busy)
  // A left word is always followed at once by its right word.
  `TSPBC_ASSERT_NEXT(a_right_follows, clk, rst, strobe && !last, strobe && last)
  // Never two right words in a row.
  `TSPBC_ASSERT_NEXT(a_no_double_right, clk, rst, strobe && last, !(strobe && last))
  // An absent box reads as zero and carries the side in last.
  `TSPBC_ASSERT_IMPL(a_absent_zero, clk, rst, strobe && !present, min_x == '0 && max_z == '0 && side == last)

endmodule

bind triangle_split_plane_box_clip_unit tspbc_checker #(.COORD_BITS(COORD_BITS)) u_chk (.*);
